### rtl/core/si_pkg.sv
// Package for the segment intersection block: default coordinate width.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package si_pkg;
    localparam int COORD_WIDTH = 24;
endpackage
`default_nettype wire

### rtl/core/si_in_if.sv
// Input channel carrying one pair of segments per word.
// Depends on si_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface si_in_if #(
    parameter int W = si_pkg::COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ax_start;
    logic signed [W-1:0] ay_start;
    logic signed [W-1:0] ax_end;
    logic signed [W-1:0] ay_end;
    logic signed [W-1:0] bx_start;
    logic signed [W-1:0] by_start;
    logic signed [W-1:0] bx_end;
    logic signed [W-1:0] by_end;

    modport source (output valid, ax_start, ay_start, ax_end, ay_end,
                    bx_start, by_start, bx_end, by_end, input ready);
    modport sink (input valid, ax_start, ay_start, ax_end, ay_end,
                  bx_start, by_start, bx_end, by_end, output ready);
endinterface
`default_nettype wire

### rtl/core/si_out_if.sv
// Output channel carrying one crossing result per word.
// Depends on si_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface si_out_if #(
    parameter int W = si_pkg::COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

### rtl/core/segment_intersection.sv
// Segment intersection: determinant test and floor-rounded crossing point, pipelined.
// Depends on si_pkg, si_in_if and si_out_if.
//
//   channel   | dir | contents
//   in_word   | in  | two segments, eight signed coordinates
//   out_word  | out | hit flag and crossing point
//
// One word enters every cycle unless back-pressure from out_word stalls it.
// The crossing-point divider retires one quotient bit of each coordinate
// per stage.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds only while it is full and its successor is stalled, so bubbles fill.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection #(
    parameter int COORD_WIDTH = si_pkg::COORD_WIDTH
) (
    input  wire    clk,
    input  wire    rst_n,
    si_in_if.sink    in_word,
    si_out_if.source out_word
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int MW = 2 * DW;
    localparam int PW = 2 * DW + 1;
    localparam int RW = PW + 1;
    localparam int DS = 5;
    localparam int NS = W + 6;

    typedef struct packed {
        logic signed [DW-1:0] dx12;
        logic signed [DW-1:0] dy12;
        logic signed [DW-1:0] dx34;
        logic signed [DW-1:0] dy34;
        logic signed [DW-1:0] dx13;
        logic signed [DW-1:0] dy13;
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [W-1:0]  bx;
        logic signed [W-1:0]  by;
    } s0_t;

    typedef struct packed {
        logic signed [MW-1:0] pa;
        logic signed [MW-1:0] pb;
        logic signed [MW-1:0] pc;
        logic signed [MW-1:0] pd;
        logic signed [MW-1:0] pe;
        logic signed [MW-1:0] pf;
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [W-1:0]  bx;
        logic signed [W-1:0]  by;
    } s1_t;

    typedef struct packed {
        logic signed [PW-1:0] den;
        logic signed [PW-1:0] tn;
        logic signed [PW-1:0] un;
        logic                 nz;
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [W-1:0]  bx;
        logic signed [W-1:0]  by;
    } s2_t;

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [W-1:0]  q_x;
        logic [W-1:0]  q_y;
        logic [RW-1:0] num;
        logic [RW-1:0] den;
        logic [W-1:0]  md_x;
        logic [W-1:0]  md_y;
        logic          neg_x;
        logic          neg_y;
        logic [W-1:0]  bx;
        logic [W-1:0]  by;
        logic          hit;
    } dv_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s2_t s3_reg, s3_next;
    dv_t dv_reg  [0:W];
    dv_t dv_next [0:W];

    logic          hit_reg;
    logic [W-1:0]  cx_reg, cx_next;
    logic [W-1:0]  cy_reg, cy_next;

    always_comb
    begin
        en[NS] = out_word.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = ~v_reg[i] | en[i+1];
        end
    end

    assign in_word.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    if (i == 0)
                        v_reg[i] <= in_word.valid;
                    else
                        v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: coordinate differences.
    always_comb
    begin
        s0_next.dx12 = DW'(in_word.ax_start) - DW'(in_word.ax_end);
        s0_next.dy12 = DW'(in_word.ay_start) - DW'(in_word.ay_end);
        s0_next.dx34 = DW'(in_word.bx_start) - DW'(in_word.bx_end);
        s0_next.dy34 = DW'(in_word.by_start) - DW'(in_word.by_end);
        s0_next.dx13 = DW'(in_word.ax_start) - DW'(in_word.bx_start);
        s0_next.dy13 = DW'(in_word.ay_start) - DW'(in_word.by_start);
        s0_next.ddx  = DW'(in_word.bx_end) - DW'(in_word.bx_start);
        s0_next.ddy  = DW'(in_word.by_end) - DW'(in_word.by_start);
        s0_next.bx   = in_word.bx_start;
        s0_next.by   = in_word.by_start;
    end

    // Stage 1: the six products.
    always_comb
    begin
        s1_next.pa  = MW'(s0_reg.dx12) * MW'(s0_reg.dy34);
        s1_next.pb  = MW'(s0_reg.dy12) * MW'(s0_reg.dx34);
        s1_next.pc  = MW'(s0_reg.dx13) * MW'(s0_reg.dy34);
        s1_next.pd  = MW'(s0_reg.dy13) * MW'(s0_reg.dx34);
        s1_next.pe  = MW'(s0_reg.dx12) * MW'(s0_reg.dy13);
        s1_next.pf  = MW'(s0_reg.dy12) * MW'(s0_reg.dx13);
        s1_next.ddx = s0_reg.ddx;
        s1_next.ddy = s0_reg.ddy;
        s1_next.bx  = s0_reg.bx;
        s1_next.by  = s0_reg.by;
    end

    // Stage 2: determinant and the two numerators.
    always_comb
    begin
        s2_next.den = PW'(s1_reg.pa) - PW'(s1_reg.pb);
        s2_next.tn  = PW'(s1_reg.pc) - PW'(s1_reg.pd);
        s2_next.un  = PW'(s1_reg.pf) - PW'(s1_reg.pe);
        s2_next.nz  = 1'b0;
        s2_next.ddx = s1_reg.ddx;
        s2_next.ddy = s1_reg.ddy;
        s2_next.bx  = s1_reg.bx;
        s2_next.by  = s1_reg.by;
    end

    // Stage 3: make the determinant non-negative.
    always_comb
    begin
        s3_next    = s2_reg;
        s3_next.nz = (s2_reg.den != '0);
        if (s2_reg.den[PW-1])
        begin
            s3_next.den = -s2_reg.den;
            s3_next.tn  = -s2_reg.tn;
            s3_next.un  = -s2_reg.un;
        end
    end

    // Stage 4: range checks and divider setup.
    always_comb
    begin
        dv_next[0].hit = s3_reg.nz & ~s3_reg.tn[PW-1] & ~s3_reg.un[PW-1]
                       & (s3_reg.tn <= s3_reg.den) & (s3_reg.un <= s3_reg.den);
        dv_next[0].rem_x = '0;
        dv_next[0].rem_y = '0;
        dv_next[0].q_x   = '0;
        dv_next[0].q_y   = '0;
        dv_next[0].num   = RW'(unsigned'(s3_reg.un));
        dv_next[0].den   = RW'(unsigned'(s3_reg.den));
        dv_next[0].neg_x = s3_reg.ddx[DW-1];
        dv_next[0].neg_y = s3_reg.ddy[DW-1];
        dv_next[0].md_x  = s3_reg.ddx[DW-1] ? W'(-s3_reg.ddx) : W'(s3_reg.ddx);
        dv_next[0].md_y  = s3_reg.ddy[DW-1] ? W'(-s3_reg.ddy) : W'(s3_reg.ddy);
        dv_next[0].bx    = s3_reg.bx;
        dv_next[0].by    = s3_reg.by;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s0_reg <= s0_next;
        if (en[1])
            s1_reg <= s1_next;
        if (en[2])
            s2_reg <= s2_next;
        if (en[3])
            s3_reg <= s3_next;
        if (en[4])
            dv_reg[0] <= dv_next[0];
    end

    // Divider stages: one quotient bit of each coordinate per stage.
    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [RW-1:0] rx, ry, den1, den2;

        always_comb
        begin
            den1 = dv_reg[k].den;
            den2 = {dv_reg[k].den[RW-2:0], 1'b0};
            rx   = {dv_reg[k].rem_x[RW-2:0], 1'b0}
                 + (dv_reg[k].md_x[W-1-k] ? dv_reg[k].num : '0);
            ry   = {dv_reg[k].rem_y[RW-2:0], 1'b0}
                 + (dv_reg[k].md_y[W-1-k] ? dv_reg[k].num : '0);
            dv_next[k+1] = dv_reg[k];
            if (rx >= den2)
            begin
                dv_next[k+1].rem_x = rx - den2;
                dv_next[k+1].q_x   = {dv_reg[k].q_x[W-2:0], 1'b0} + W'(2);
            end
            else if (rx >= den1)
            begin
                dv_next[k+1].rem_x = rx - den1;
                dv_next[k+1].q_x   = {dv_reg[k].q_x[W-2:0], 1'b1};
            end
            else
            begin
                dv_next[k+1].rem_x = rx;
                dv_next[k+1].q_x   = {dv_reg[k].q_x[W-2:0], 1'b0};
            end
            if (ry >= den2)
            begin
                dv_next[k+1].rem_y = ry - den2;
                dv_next[k+1].q_y   = {dv_reg[k].q_y[W-2:0], 1'b0} + W'(2);
            end
            else if (ry >= den1)
            begin
                dv_next[k+1].rem_y = ry - den1;
                dv_next[k+1].q_y   = {dv_reg[k].q_y[W-2:0], 1'b1};
            end
            else
            begin
                dv_next[k+1].rem_y = ry;
                dv_next[k+1].q_y   = {dv_reg[k].q_y[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[DS+k])
                dv_reg[k+1] <= dv_next[k+1];
        end
    end

    // Final stage: add the scaled offset to the start point, floor rounding; a miss gives zero.
    always_comb
    begin
        if (dv_reg[W].neg_x)
            cx_next = dv_reg[W].bx - dv_reg[W].q_x - W'(dv_reg[W].rem_x != '0);
        else
            cx_next = dv_reg[W].bx + dv_reg[W].q_x;
        if (dv_reg[W].neg_y)
            cy_next = dv_reg[W].by - dv_reg[W].q_y - W'(dv_reg[W].rem_y != '0);
        else
            cy_next = dv_reg[W].by + dv_reg[W].q_y;
        if (!dv_reg[W].hit)
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            hit_reg <= dv_reg[W].hit;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign out_word.valid   = v_reg[NS-1];
    assign out_word.hit     = hit_reg;
    assign out_word.cross_x = cx_reg;
    assign out_word.cross_y = cy_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_word.valid && !out_word.hit |-> out_word.cross_x == '0 && out_word.cross_y == '0)
        else $error("miss word carries a nonzero crossing point");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_word.valid && in_word.ready |=> v_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[DS] && !en[DS] |=> v_reg[DS] && $stable(dv_reg[1].num))
        else $error("stalled divider stage lost its word");

endmodule
`default_nettype wire
